// ===== hdl/topic_filter_wildcard_match_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the topic filter match unit
// Shared shorthand for the concurrent checks of the block's checker.
// ----------------------------------------------------------------------------
`ifndef TOPIC_FILTER_WILDCARD_MATCH_UNIT_MACROS_SVH
`define TOPIC_FILTER_WILDCARD_MATCH_UNIT_MACROS_SVH

// Check that is switched off while the synchronous reset is held low.
`define TFWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that is also evaluated around reset.
`define TFWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tfwm_pkg.sv =====
// ----------------------------------------------------------------------------
// tfwm_pkg
// Constants and types of the topic filter wildcard match unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tfwm_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned FILTER_LEN = 64;
    localparam int unsigned POS_W      = 7;
    localparam int unsigned CFG_REGS   = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned FILTER_W   = FILTER_LEN * CHAR_W;
    localparam int unsigned WIN_W      = 3 * CHAR_W;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        PH_COMPARE = 3'b001,
        PH_SKIP    = 3'b010,
        PH_DECIDED = 3'b100
    } t_phase;

    // Filter position step that stops one past the last filter byte.
    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
        return (p < POS_W'(FILTER_LEN)) ? p + POS_W'(1) : p;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/topic_filter_wildcard_match_unit.sv =====
// ----------------------------------------------------------------------------
// topic_filter_wildcard_match_unit
// Streams a topic byte by byte and matches it against a wildcard filter.
// ----------------------------------------------------------------------------
// Usage:
// The filter (up to 64 bytes, ending at its first zero byte) is written
// through the configuration port, eight bytes per register, lowest byte
// first, while no topic is in flight. Topic bytes enter on the s_axis
// channel, one item per byte. A zero byte ends the topic; for it, and only
// for it, one item leaves on the m_axis channel with the match flag in bit 0.
// An accepted zero byte waits in the input register and is then judged into
// the result register, which raises m_axis_tvalid. Throughput is one byte
// per cycle while no zero byte waits on a pending result; the compare of a
// byte against the filter window and the state update are combinational
// between the input register and the state and result registers.
// Reset clears the filter registers, the stream state and both valid flags.
// When the receiver stalls, the result is held in the output register and
// nonzero bytes keep flowing; a second zero byte waits in the input register
// with s_axis_tready low until the pending result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module topic_filter_wildcard_match_unit
    import tfwm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Topic byte stream.
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] topic_char
    // Match results.
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output      logic [7:0]            m_axis_tdata    // [0] matched, [7:1] zero
);

    // Filter storage, byte 0 in the lowest bits.
    logic [FILTER_W-1:0] r_filter;

    // Input register.
    logic              r_in_vld;
    logic [CHAR_W-1:0] r_in_data;

    // Stream state.
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_phase           r_phase;
    t_phase           n_phase;
    logic             r_verdict;
    logic             n_verdict;
    logic             r_slash_due;
    logic             n_slash_due;

    // Result register.
    logic r_out_vld;
    logic r_out_matched;

    logic                      w_advance;
    logic                      w_end;
    logic [FILTER_W+WIN_W-1:0] w_ext;
    logic [FILTER_W+WIN_W-1:0] w_shift;
    logic [CHAR_W-1:0]         w_f0;
    logic [CHAR_W-1:0]         w_f1;
    logic [CHAR_W-1:0]         w_f2;
    logic [CHAR_W-1:0]         w_c;

    // A nonzero byte never produces a result, so it can always move on; a
    // zero byte needs the result register to be free or draining.
    assign w_c       = r_in_data;
    assign w_end     = (w_c == CH_NUL);
    assign w_advance = r_in_vld && (!w_end || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_advance;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_out_matched};

    // Three filter bytes starting at the current position. Positions past
    // the end of the filter read as zero through the padding.
    assign w_ext   = {WIN_W'(0), r_filter};
    assign w_shift = w_ext >> {r_pos, 3'b000};
    assign w_f0    = w_shift[CHAR_W-1:0];
    assign w_f1    = w_shift[2*CHAR_W-1:CHAR_W];
    assign w_f2    = w_shift[3*CHAR_W-1:2*CHAR_W];

    always_comb begin
        logic run_cmp;
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_verdict   = r_verdict;
        n_slash_due = r_slash_due;
        run_cmp     = 1'b0;

        case (r_phase)
            PH_SKIP: begin
                // A '+' swallows bytes until a '/' or the end of the topic.
                if (w_c == CH_SLASH) begin
                    if (w_f1 == CH_SLASH) begin
                        n_pos       = pos_inc(pos_inc(r_pos));
                        n_phase     = PH_COMPARE;
                        n_slash_due = 1'b0;
                    end else begin
                        n_pos       = pos_inc(r_pos);
                        n_phase     = PH_DECIDED;
                        n_verdict   = 1'b0;
                        n_slash_due = 1'b1;
                    end
                end else if (w_end) begin
                    n_phase   = PH_DECIDED;
                    n_verdict = (w_f1 != CH_SLASH) &&
                                ((w_f1 == CH_NUL) || ((w_f1 == CH_HASH) && (w_f2 == CH_NUL)));
                end
            end
            PH_COMPARE: begin
                if (r_slash_due) begin
                    // After a matched byte, a level separator must line up.
                    if ((w_f0 == CH_SLASH) && (w_c == CH_SLASH)) begin
                        n_pos       = pos_inc(r_pos);
                        n_slash_due = 1'b0;
                    end else if ((w_f0 == CH_SLASH) || (w_c == CH_SLASH)) begin
                        n_phase   = PH_DECIDED;
                        n_verdict = 1'b0;
                    end else begin
                        n_slash_due = 1'b0;
                        run_cmp     = 1'b1;
                    end
                end else begin
                    run_cmp = 1'b1;
                end

                if (run_cmp) begin
                    if (w_end) begin
                        n_phase   = PH_DECIDED;
                        n_verdict = (w_f0 == CH_NUL) ||
                                    ((w_f0 == CH_HASH) && (w_f1 == CH_NUL));
                    end else if (w_f0 == CH_NUL) begin
                        n_phase   = PH_DECIDED;
                        n_verdict = 1'b0;
                    end else if (w_f0 == CH_PLUS) begin
                        if (w_c == CH_SLASH) begin
                            // Empty level under '+': step past it at once.
                            if (w_f1 == CH_SLASH) begin
                                n_pos       = pos_inc(pos_inc(r_pos));
                                n_slash_due = 1'b0;
                            end else begin
                                n_pos       = pos_inc(r_pos);
                                n_phase     = PH_DECIDED;
                                n_verdict   = 1'b0;
                                n_slash_due = 1'b1;
                            end
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else if (w_f0 == CH_HASH) begin
                        n_phase   = PH_DECIDED;
                        n_verdict = 1'b1;
                    end else if (w_f0 != w_c) begin
                        n_phase   = PH_DECIDED;
                        n_verdict = 1'b0;
                    end else begin
                        n_pos       = pos_inc(r_pos);
                        n_slash_due = 1'b1;
                    end
                end
            end
            default: begin
                // Outcome already known; bytes are ignored until the end.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= '0;
        end else if (i_cfg_we) begin
            r_filter[{i_cfg_addr, 6'b000000} +: CFG_DATA_W] <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_phase     <= PH_COMPARE;
            r_verdict   <= 1'b0;
            r_slash_due <= 1'b0;
        end else if (w_advance) begin
            if (w_end) begin
                // End of topic: the stream state starts over.
                r_pos       <= '0;
                r_phase     <= PH_COMPARE;
                r_verdict   <= 1'b0;
                r_slash_due <= 1'b0;
            end else begin
                r_pos       <= n_pos;
                r_phase     <= n_phase;
                r_verdict   <= n_verdict;
                r_slash_due <= n_slash_due;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance && w_end) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_end) begin
            r_out_matched <= n_verdict;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tfwm_checker.sv =====
// ----------------------------------------------------------------------------
// tfwm_checker
// Port-level checks of the topic filter match unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "topic_filter_wildcard_match_unit_macros.svh"

module tfwm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic [2:0]  i_cfg_addr,
    input wire logic [63:0] i_cfg_wdata,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    logic w_zero_in;
    logic w_stalled;
    logic w_in_blocked;
    logic w_out_pending;

    assign w_zero_in     = s_axis_tvalid && s_axis_tready && (s_axis_tdata == 8'h00);
    assign w_stalled     = m_axis_tvalid && !m_axis_tready;
    assign w_in_blocked  = !s_axis_tready;
    assign w_out_pending = m_axis_tvalid && !m_axis_tready;

    // Input backpressure only comes from a result that is waiting.
    `TFWM_ASSERT(a_block_needs_stall, i_clk, i_rst_n, w_in_blocked |-> w_out_pending, "input blocked without a stalled result")

    // A zero byte that is taken in reaches the output if the receiver is ready.
    `TFWM_ASSERT(a_result_latency, i_clk, i_rst_n, w_zero_in ##1 m_axis_tready |=> m_axis_tvalid, "end of topic gave no result")

    // A stalled result holds its value.
    `TFWM_ASSERT(a_hold_on_stall, i_clk, i_rst_n, w_stalled |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // No result is offered right after reset.
    `TFWM_ASSERT_ALWAYS(a_quiet_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid, "result offered after reset")

endmodule

bind topic_filter_wildcard_match_unit tfwm_checker u_tfwm_checker (.*);

`default_nettype wire

// ===== dv/tb_topic_filter_wildcard_match_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_topic_filter_wildcard_match_unit
// Self-checking testbench of the topic filter wildcard match unit. A table of
// short topics and filters is played first, then random filters with topics
// mostly derived from them. Each result is checked against an in-bench matcher
// or a pinned case's typed-in bit, under changing backpressure on both streams.
// ----------------------------------------------------------------------------

module tb_topic_filter_wildcard_match_unit;

    import tfwm_pkg::*;

    // Cycles allowed after the last result before the filter is rewritten or the run ends.
    localparam int SETTLE_CYCLES = 4;
    // Length of the one long receiver stall that fills the block up.
    localparam int HOLD_CYCLES   = 300;
    // Cycles without any handshake after which the run is declared hung.
    localparam int QUIET_LIMIT   = 4000;
    // Rough number of items sent per idling regime in the random part.
    localparam int REGIME_ITEMS  = 490;
    localparam int N_CASES       = 17;

    // Pseudo filter kinds used to force the extremes of the registers.
    localparam int KIND_RANDOM   = 0;
    localparam int KIND_ALL_ONES = 1;
    localparam int KIND_FULL     = 2;
    localparam int KIND_EMPTY    = 3;

    // One directed case: filter and topic, both with byte 0 in the low bits.
    // When pinned is set, the expected outcome is the typed-in want bit.
    typedef struct packed {
        logic [FILTER_W-1:0] filt;
        logic [FILTER_W-1:0] topic;
        logic                pinned;
        logic                want;
    } case_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] topic_char
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // [0] matched, [7:1] zero

    topic_filter_wildcard_match_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Matcher state kept by the bench. It starts at its reset values, which
    // is enough since reset is applied only once.
    // ------------------------------------------------------------------------
    logic [FILTER_W-1:0] filter_mirror = '0;
    logic [POS_W-1:0]    pred_pos = '0;
    t_phase              pred_phase = PH_COMPARE;
    logic                pred_verdict = 1'b0;
    logic                pred_slash_due = 1'b0;

    // Outcomes still owed by the block, oldest first.
    logic                verdict_q[$];
    // One entry per zero byte offered: {pinned, want}.
    logic [1:0]          typed_verdict_q[$];
    // Bytes of the next topic, without its terminating zero.
    logic [7:0]          topic_bytes[$];

    int mismatches    = 0;
    int sent_items    = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    // Filter byte at a position; positions past the last byte read as zero.
    function automatic logic [7:0] filter_char(input int pos);
        if (pos >= FILTER_LEN) begin
            return CH_NUL;
        end
        return filter_mirror[8*pos +: 8];
    endfunction

    function automatic void step_filter();
        if (pred_pos < POS_W'(FILTER_LEN)) begin
            pred_pos = pred_pos + 1'b1;
        end
    endfunction

    function automatic void conclude(input logic v);
        pred_phase   = PH_DECIDED;
        pred_verdict = v;
    endfunction

    // Advances the matcher by one topic byte. Returns 1 when the byte ends
    // the topic, with the outcome in hit; the stream state is then cleared.
    function automatic bit judge_char(input logic [7:0] c, output logic hit);
        logic [7:0] f;
        bit         done;
        done = 1'b0;
        hit  = 1'b0;
        // A byte may pass through a few phases (leave '+', check the slash,
        // compare), so the walk repeats until the byte has been consumed.
        for (int k = 0; k < 8 && !done; k++) begin
            if (pred_phase == PH_DECIDED) begin
                done = 1'b1;
            end else if (pred_phase == PH_SKIP) begin
                if (c != CH_NUL && c != CH_SLASH) begin
                    done = 1'b1;
                end else begin
                    step_filter();
                    pred_phase     = PH_COMPARE;
                    pred_slash_due = 1'b1;
                end
            end else if (pred_slash_due) begin
                f = filter_char(int'(pred_pos));
                if (f == CH_SLASH && c == CH_SLASH) begin
                    step_filter();
                    pred_slash_due = 1'b0;
                    done           = 1'b1;
                end else if (f == CH_SLASH || c == CH_SLASH) begin
                    conclude(1'b0);
                end else begin
                    pred_slash_due = 1'b0;
                end
            end else begin
                f = filter_char(int'(pred_pos));
                if (c == CH_NUL) begin
                    conclude(f == CH_NUL ||
                             (f == CH_HASH && filter_char(int'(pred_pos) + 1) == CH_NUL));
                end else if (f == CH_NUL) begin
                    conclude(1'b0);
                end else if (f == CH_PLUS) begin
                    pred_phase = PH_SKIP;
                end else if (f == CH_HASH) begin
                    conclude(1'b1);
                end else if (f != c) begin
                    conclude(1'b0);
                end else begin
                    step_filter();
                    pred_slash_due = 1'b1;
                    done           = 1'b1;
                end
            end
        end
        if (c == CH_NUL) begin
            hit            = pred_verdict;
            pred_pos       = '0;
            pred_phase     = PH_COMPARE;
            pred_verdict   = 1'b0;
            pred_slash_due = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: every accepted byte goes through the matcher. A zero byte
    // adds one expected outcome, typed in for the pinned directed cases.
    // Output side: every accepted result is compared with the oldest one.
    // Both sides sample the values from before the edge, so the order of
    // processes within the time step does not matter.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        logic       hit;
        logic [1:0] pin;
        logic       owed;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (judge_char(s_axis_tdata, hit)) begin
                pin = typed_verdict_q.pop_front();
                verdict_q.push_back(pin[1] ? pin[0] : hit);
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("matched: no result expected, got %0b", m_axis_tdata[0]);
                mismatches++;
            end else begin
                owed = verdict_q.pop_front();
                if (m_axis_tdata[0] !== owed) begin
                    $error("matched: expected %0b, got %0b", owed, m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tdata[7:1] !== 7'd0) begin
                    $error("padding: expected 0, got %0h", m_axis_tdata[7:1]);
                    mismatches++;
                end
            end
        end
    end

    // The receiver takes results at random, except during the one long
    // stall, which it counts down here while the sender keeps offering.
    always @(posedge i_clk) begin : drive_ready
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // A run where neither stream moves for too long is hung.
    always @(posedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offers one topic byte after a random gap and returns at the edge that
    // accepts it; tvalid stays high so back-to-back bytes need no bubble.
    task automatic push_char(input logic [7:0] c, input logic pinned, input logic want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        if (c == CH_NUL) begin
            typed_verdict_q.push_back({pinned, want});
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    // Stops offering, waits for every owed result and lets the block drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all eight filter registers; only called while the block is idle.
    task automatic load_filter(input logic [FILTER_W-1:0] f);
        for (int r = 0; r < CFG_REGS; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= CFG_IDX_W'(r);
            i_cfg_wdata <= f[CFG_DATA_W*r +: CFG_DATA_W];
            @(posedge i_clk);
        end
        i_cfg_we      <= 1'b0;
        filter_mirror = f;
    endtask

    // Turns a string literal (last character lowest) into byte-0-first order.
    function automatic logic [FILTER_W-1:0] lit_order(input logic [FILTER_W-1:0] v);
        logic [FILTER_W-1:0] r;
        int                  n;
        r = '0;
        n = 0;
        while (n < FILTER_LEN && v[8*n +: 8] != CH_NUL) begin
            n++;
        end
        for (int i = 0; i < n; i++) begin
            r[8*i +: 8] = v[8*(n-1-i) +: 8];
        end
        return r;
    endfunction

    function automatic case_row_t mk_case(input logic [FILTER_W-1:0] f,
                                          input logic [FILTER_W-1:0] t,
                                          input logic pinned, input logic want);
        case_row_t row;
        row.filt   = lit_order(f);
        row.topic  = lit_order(t);
        row.pinned = pinned;
        row.want   = want;
        return row;
    endfunction

    // A byte that is neither zero nor a slash, biased toward a tiny alphabet
    // so that derived topics and random filters agree often.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        if ($urandom_range(1) == 0) begin
            c = "a" + 8'($urandom_range(2));
        end else begin
            c = 8'($urandom_range(1, 255));
        end
        if (c == CH_SLASH) begin
            c = "b";
        end
        return c;
    endfunction

    task automatic pick_filter(input int kind, output logic [FILTER_W-1:0] f);
        int         len;
        int         roll;
        logic [7:0] b;
        f = '0;
        if (kind == KIND_ALL_ONES) begin
            f = '1;
        end else if (kind != KIND_EMPTY) begin
            len = (kind == KIND_FULL || $urandom_range(19) == 0) ? FILTER_LEN
                                                                  : $urandom_range(0, 10);
            for (int i = 0; i < len; i++) begin
                roll = $urandom_range(19);
                if (roll < 4) begin
                    b = CH_SLASH;
                end else if (roll < 7) begin
                    b = CH_PLUS;
                end else if (roll < 9) begin
                    b = CH_HASH;
                end else begin
                    b = word_char();
                end
                f[8*i +: 8] = b;
            end
        end
    endtask

    // Builds the next topic. Most topics follow the filter level by level,
    // with an occasional stray byte, cut short or run on; the rest are noise.
    task automatic build_topic(input logic [FILTER_W-1:0] f);
        int         mode;
        int         keep;
        logic [7:0] b;
        topic_bytes.delete();
        mode = $urandom_range(9);
        if (mode < 2) begin
            repeat ($urandom_range(0, 8)) topic_bytes.push_back(8'($urandom_range(1, 255)));
        end else begin
            for (int i = 0; i < FILTER_LEN; i++) begin
                b = f[8*i +: 8];
                if (b == CH_NUL) begin
                    break;
                end
                if (b == CH_PLUS) begin
                    repeat ($urandom_range(0, 3)) topic_bytes.push_back(word_char());
                end else if (b == CH_HASH) begin
                    repeat ($urandom_range(0, 4)) topic_bytes.push_back(
                        ($urandom_range(3) == 0) ? CH_SLASH : word_char());
                end else begin
                    topic_bytes.push_back(b);
                end
                if ($urandom_range(99) < 3) begin
                    topic_bytes.push_back(8'($urandom_range(1, 255)));
                end
            end
            if (mode == 2) begin
                keep = $urandom_range(0, topic_bytes.size());
                while (topic_bytes.size() > keep) begin
                    void'(topic_bytes.pop_back());
                end
            end else if (mode == 3) begin
                topic_bytes.push_back(CH_SLASH);
                repeat ($urandom_range(0, 2)) topic_bytes.push_back(word_char());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    case_row_t case_tab [N_CASES];

    initial begin : run_test
        logic [FILTER_W-1:0] f;
        int                  goal;
        int                  phase_no;
        logic [7:0]          b;

        // Directed cases. The filter is only rewritten when it changes.
        case_tab[0]  = mk_case("",      "",     1'b1, 1'b1); // empty topic, empty filter
        case_tab[1]  = mk_case("",      "a",    1'b1, 1'b0); // filter ends first
        case_tab[2]  = mk_case("#",     "",     1'b1, 1'b1); // empty topic under '#'
        case_tab[3]  = mk_case("#",     "a/b",  1'b1, 1'b1);
        case_tab[4]  = mk_case("a/#",   "a",    1'b1, 1'b0); // slash check beats the '#'
        case_tab[5]  = mk_case("a/#",   "a/",   1'b1, 1'b1);
        case_tab[6]  = mk_case("a#x",   "ab",   1'b1, 1'b1); // '#' in mid-level
        case_tab[7]  = mk_case("+/b",   "xy/b", 1'b0, 1'b0);
        case_tab[8]  = mk_case("+",     "#+",   1'b0, 1'b0); // wildcards as topic data
        case_tab[9]  = mk_case("+",     "",     1'b0, 1'b0);
        case_tab[10] = mk_case("a/+",   "a/",   1'b0, 1'b0);
        case_tab[11] = mk_case("ab",    "axbq", 1'b1, 1'b0); // decided early, rest ignored
        case_tab[12] = mk_case("a",     "a/",   1'b1, 1'b0); // slash on the topic side only
        case_tab[13] = mk_case("a/b",   "ab",   1'b1, 1'b0); // slash on the filter side only
        case_tab[14] = mk_case("\377\001", "\377\001", 1'b1, 1'b1); // extreme byte values
        // A filter with no terminator: 32 levels of "+/", matched by 32 slashes,
        // so the zero byte lands on the position just past the last byte.
        case_tab[15] = mk_case("", "", 1'b1, 1'b1);
        for (int i = 0; i < FILTER_LEN; i += 2) begin
            case_tab[15].filt[8*i +: 16] = {CH_SLASH, CH_PLUS};
            case_tab[15].topic[4*i +: 8] = CH_SLASH;
        end
        case_tab[16] = mk_case("a/b",   "a/b",  1'b1, 1'b1);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 12;
        sink_idle_pct = 80;
        for (int n = 0; n < N_CASES; n++) begin
            if (case_tab[n].filt !== filter_mirror) begin
                settle();
                load_filter(case_tab[n].filt);
            end
            for (int i = 0; i < FILTER_LEN; i++) begin
                b = case_tab[n].topic[8*i +: 8];
                if (b == CH_NUL) begin
                    break;
                end
                push_char(b, 1'b0, 1'b0);
            end
            push_char(CH_NUL, case_tab[n].pinned, case_tab[n].want);
        end

        // Random part in three regimes: slow receiver, slow sender, no idling.
        // Each phase loads a fresh filter and plays a handful of topics; the
        // first phase of each regime forces one register extreme.
        goal = sent_items;
        for (int regime = 0; regime < 3; regime++) begin
            src_idle_pct  = (regime == 0) ? 12 : (regime == 1) ? 80 : 0;
            sink_idle_pct = (regime == 0) ? 80 : (regime == 1) ? 12 : 0;
            goal          = goal + REGIME_ITEMS;
            phase_no      = 0;
            while (sent_items < goal) begin
                settle();
                pick_filter((phase_no != 0) ? KIND_RANDOM   :
                            (regime == 0)   ? KIND_ALL_ONES :
                            (regime == 1)   ? KIND_FULL     : KIND_EMPTY, f);
                load_filter(f);
                // Once, with nothing else slowing it down, the receiver
                // stops for a long stretch while topics keep coming, so the
                // block holds a result and then refuses the next zero byte.
                if (regime == 2 && phase_no == 0) begin
                    hold_asked++;
                end
                repeat ($urandom_range(4, 10)) begin
                    build_topic(f);
                    foreach (topic_bytes[i]) begin
                        push_char(topic_bytes[i], 1'b0, 1'b0);
                    end
                    push_char(CH_NUL, 1'b0, 1'b0);
                end
                phase_no++;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== topic_filter_wildcard_match_unit.f =====
+incdir+hdl
hdl/tfwm_pkg.sv
hdl/topic_filter_wildcard_match_unit.sv
hdl/tfwm_checker.sv
dv/tb_topic_filter_wildcard_match_unit.sv
